// File: hw/rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin tick scheduler: request and
// result structs, job table word and the control groups between the parts.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // job table and ready ring depth, a power of two
  localparam int QUEUE_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = DEPTH_W + 1;
  localparam int ID_W        = 7;
  localparam int TIME_W      = 16;
  localparam int SERV_W      = 16;

  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] arrival_time;
    logic [SERV_W-1:0] service_time;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] slot_time;
    logic [ID_W-1:0]   running_id;
    logic              all_done;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [SERV_W-1:0] remaining;
  } job_t;

  typedef struct packed {
    logic               wr_en;
    logic [DEPTH_W-1:0] wr_addr;
    job_t               wr_data;
    logic               rd_en;
    logic [DEPTH_W-1:0] rd_addr;
  } job_req_t;

  typedef struct packed {
    logic            push;
    logic [ID_W-1:0] push_id;
    logic            rd_en;
    logic            pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  rd_id;
  } fifo_sts_t;

endpackage

// File: hw/rtl/rrts_job_mem.sv
// ----------------------------------------------------------------------------
// rrts_job_mem
// Job table: arrival and remaining service per id, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module rrts_job_mem (
  input  logic              clk,
  input  rrts_pkg::job_req_t req,
  output rrts_pkg::job_t     rd_data
);

  rrts_pkg::job_t mem [rrts_pkg::QUEUE_DEPTH];
  rrts_pkg::job_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/rrts_ready_fifo.sv
// ----------------------------------------------------------------------------
// rrts_ready_fifo
// Ready ring of job ids held in a memory, with head pointer and fill count.
// The head entry is read in the cycle before it is popped.
// ----------------------------------------------------------------------------
module rrts_ready_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  rrts_pkg::fifo_ctl_t ctl,
  output rrts_pkg::fifo_sts_t sts
);

  logic [rrts_pkg::ID_W-1:0]    mem [rrts_pkg::QUEUE_DEPTH];
  logic [rrts_pkg::ID_W-1:0]    rd_id_r;
  logic [rrts_pkg::DEPTH_W-1:0] head_r, head_nxt;
  logic [rrts_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [rrts_pkg::DEPTH_W-1:0] tail;
  logic                         full;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count_r == rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH));
  assign tail    = head_r + count_r[rrts_pkg::DEPTH_W-1:0];
  assign do_push = ctl.push && !full;
  assign do_pop  = ctl.pop && (count_r != '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (do_pop) begin
      head_nxt = head_r + rrts_pkg::DEPTH_W'(1);
    end
    priority if (do_push && !do_pop) begin
      count_nxt = count_r + rrts_pkg::CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - rrts_pkg::CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctl.push_id;
    end
    if (ctl.rd_en) begin
      rd_id_r <= mem[head_r];
    end
  end

  assign sts.count = count_r;
  assign sts.rd_id = rd_id_r;

  // the sequencer never pushes and pops in the same cycle
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("ready ring pushed and popped together");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rrts_pkg::CNT_W'(rrts_pkg::QUEUE_DEPTH))
    else $error("ready ring count beyond depth");

endmodule

// File: hw/rtl/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Tick sequencer: admits due jobs, charges and requeues the running job,
// pops the next one and reports. Submits are written in the accept cycle.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rrts_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output rrts_pkg::out_item_t out_result,
  output rrts_pkg::job_req_t  job_req,
  input  rrts_pkg::job_t      job_rd,
  output rrts_pkg::fifo_ctl_t fifo_ctl,
  input  rrts_pkg::fifo_sts_t fifo_sts
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ADM_RD   = 8'b0000_0010,
    ST_ADM_CHK  = 8'b0000_0100,
    ST_CHG_RD   = 8'b0000_1000,
    ST_CHG_WR   = 8'b0001_0000,
    ST_POP_RD   = 8'b0010_0000,
    ST_POP_TAKE = 8'b0100_0000,
    ST_REPORT   = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [rrts_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [rrts_pkg::ID_W-1:0]    admit_id_r, admit_id_nxt;
  logic [rrts_pkg::ID_W-1:0]    running_r, running_nxt;
  logic [rrts_pkg::TIME_W-1:0]  time_r, time_nxt;
  logic                         out_valid_r, out_valid_nxt;
  rrts_pkg::out_item_t          out_result_r, out_result_nxt;

  logic                         accept;
  logic                         table_full;
  logic                         pending;
  logic [rrts_pkg::SERV_W-1:0]  rem_dec;
  logic [rrts_pkg::ID_W-1:0]    admit_m1;
  logic [rrts_pkg::ID_W-1:0]    next_m1;
  logic [rrts_pkg::ID_W-1:0]    running_m1;

  assign accept     = start && (state_r == ST_IDLE);
  assign table_full = (next_id_r > rrts_pkg::ID_W'(rrts_pkg::QUEUE_DEPTH));
  assign pending    = (admit_id_r < next_id_r);
  assign admit_m1   = admit_id_r - rrts_pkg::ID_W'(1);
  assign next_m1    = next_id_r - rrts_pkg::ID_W'(1);
  assign running_m1 = running_r - rrts_pkg::ID_W'(1);
  assign rem_dec    = (job_rd.remaining == '0) ? '0
                    : job_rd.remaining - rrts_pkg::SERV_W'(1);

  always_comb begin
    state_nxt      = state_r;
    next_id_nxt    = next_id_r;
    admit_id_nxt   = admit_id_r;
    running_nxt    = running_r;
    time_nxt       = time_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    job_req        = '0;
    fifo_ctl       = '0;
    job_req.wr_addr         = next_m1[rrts_pkg::DEPTH_W-1:0];
    job_req.wr_data.arrival   = in_item.arrival_time;
    job_req.wr_data.remaining = in_item.service_time;
    job_req.rd_addr         = admit_m1[rrts_pkg::DEPTH_W-1:0];
    fifo_ctl.push_id        = admit_id_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.req_type == rrts_pkg::REQ_TICK) begin
            state_nxt = ST_ADM_RD;
          end else if ((in_item.service_time != '0) && !table_full) begin
            job_req.wr_en = 1'b1;
            next_id_nxt   = next_id_r + rrts_pkg::ID_W'(1);
          end
        end
      end
      ST_ADM_RD: begin
        if (pending) begin
          job_req.rd_en = 1'b1;
          state_nxt     = ST_ADM_CHK;
        end else begin
          state_nxt = ST_CHG_RD;
        end
      end
      ST_ADM_CHK: begin
        if (job_rd.arrival <= time_r) begin
          fifo_ctl.push = 1'b1;
          admit_id_nxt  = admit_id_r + rrts_pkg::ID_W'(1);
          state_nxt     = ST_ADM_RD;
        end else begin
          state_nxt = ST_CHG_RD;
        end
      end
      ST_CHG_RD: begin
        if (running_r != '0) begin
          job_req.rd_en   = 1'b1;
          job_req.rd_addr = running_m1[rrts_pkg::DEPTH_W-1:0];
          state_nxt       = ST_CHG_WR;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_CHG_WR: begin
        // write back the charged job, requeue it while service remains
        job_req.wr_en             = 1'b1;
        job_req.wr_addr           = running_m1[rrts_pkg::DEPTH_W-1:0];
        job_req.wr_data.arrival   = job_rd.arrival;
        job_req.wr_data.remaining = rem_dec;
        fifo_ctl.push             = (rem_dec != '0);
        fifo_ctl.push_id          = running_r;
        running_nxt               = '0;
        state_nxt                 = ST_POP_RD;
      end
      ST_POP_RD: begin
        if (fifo_sts.count != '0) begin
          fifo_ctl.rd_en = 1'b1;
          state_nxt      = ST_POP_TAKE;
        end else begin
          running_nxt = '0;
          state_nxt   = ST_REPORT;
        end
      end
      ST_POP_TAKE: begin
        fifo_ctl.pop = 1'b1;
        running_nxt  = fifo_sts.rd_id;
        state_nxt    = ST_REPORT;
      end
      ST_REPORT: begin
        out_valid_nxt             = 1'b1;
        out_result_nxt.slot_time  = time_r;
        out_result_nxt.running_id = running_r;
        out_result_nxt.all_done   = !pending && (fifo_sts.count == '0) && (running_r == '0);
        if (time_r != '1) begin
          time_nxt = time_r + rrts_pkg::TIME_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_id_r   <= rrts_pkg::ID_W'(1);
      admit_id_r  <= rrts_pkg::ID_W'(1);
      running_r   <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_id_r   <= next_id_nxt;
      admit_id_r  <= admit_id_nxt;
      running_r   <= running_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_strobe_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_REPORT))
    else $error("result strobe without a report step");

  a_admit_order: assert property (@(posedge clk) disable iff (!rst_n)
    admit_id_r <= next_id_r)
    else $error("admit pointer passed the next id");

  a_running_known: assert property (@(posedge clk) disable iff (!rst_n)
    (running_r == '0) || (running_r < admit_id_r))
    else $error("running id was never admitted");

  a_submit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (next_id_r != $past(next_id_r)) |-> $past(state_r == ST_IDLE))
    else $error("submit taken while a tick was in progress");

endmodule

// File: hw/rtl/round_robin_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler_core
// Round-robin scheduler, one tick quantum, with job table and ready ring in
// memories and a sequencer that reads, modifies and writes them back.
// ----------------------------------------------------------------------------
// submit: taken while idle, busy stays low, no result
// tick: busy while the sequencer steps through admission, charge, pop and report;
//   each read-then-act step reads the registered job table or ready ring, then acts
// result strobe is high in the first cycle with busy low; the receiver cannot stall
// reset clears ids, pointers, time and the running job; memories are not cleared
module round_robin_tick_scheduler_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rrts_pkg::in_item_t  in_item,
  output logic                out_valid,
  output rrts_pkg::out_item_t out_result
);

  rrts_pkg::job_req_t  job_req;
  rrts_pkg::job_t      job_rd;
  rrts_pkg::fifo_ctl_t fifo_ctl;
  rrts_pkg::fifo_sts_t fifo_sts;

  rrts_job_mem u_job_mem (
    .clk     (clk),
    .req     (job_req),
    .rd_data (job_rd)
  );

  rrts_ready_fifo u_ready_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fifo_ctl),
    .sts   (fifo_sts)
  );

  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_result (out_result),
    .job_req    (job_req),
    .job_rd     (job_rd),
    .fifo_ctl   (fifo_ctl),
    .fifo_sts   (fifo_sts)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin tick scheduler. It queues submit and
// tick requests, drives them through the start/busy handshake with random
// gaps, keeps its own model of the job table and the ready ring, and checks
// every slot report in order. The run ends with a full table held back by
// late arrivals and a closing run of ticks.
// ----------------------------------------------------------------------------
module tb;
  import rrts_pkg::*;

  localparam int TIME_MAX  = (1 << TIME_W) - 1;
  localparam int LIMIT     = 4_000_000;
  localparam int TAIL_WAIT = 160;

  typedef struct {
    in_item_t req;
    bit       steady;
  } pending_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_result;

  round_robin_tick_scheduler_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  initial forever #4 clk = ~clk;

  // request plan, filled before reset is released
  pending_req_t pending[$];
  bit           steady_run = 1'b0;
  int           plan_items = 0;
  int           plan_time = 0;
  int           plan_jobs = 0;

  // scheduler state as the bench sees it
  logic [TIME_W-1:0] job_arrival_tab [QUEUE_DEPTH];
  logic [SERV_W-1:0] job_left_tab [QUEUE_DEPTH];
  int unsigned       id_next = 1;
  int unsigned       id_admit = 1;
  logic [ID_W-1:0]   ready_ring[$];
  logic [ID_W-1:0]   on_cpu = '0;
  logic [TIME_W-1:0] clock_now = '0;

  out_item_t slots_due[$];

  int accepted = 0;
  int ticks_taken = 0;
  int jobs_stored = 0;
  int submits_dropped = 0;
  int reports_seen = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // applies one request to the bench state; returns 1 with the slot report on a tick
  function automatic bit schedule_request(input in_item_t req, output out_item_t rep);
    rep = '0;
    if (req.req_type == REQ_SUBMIT) begin
      if (req.service_time != '0 && id_next <= QUEUE_DEPTH) begin
        job_arrival_tab[id_next-1] = req.arrival_time;
        job_left_tab[id_next-1]    = req.service_time;
        id_next++;
        jobs_stored++;
      end else begin
        submits_dropped++;
      end
      return 1'b0;
    end
    // admission stops at the first pending job not yet due
    while (id_admit < id_next && job_arrival_tab[id_admit-1] <= clock_now) begin
      if (ready_ring.size() < QUEUE_DEPTH) ready_ring.push_back(ID_W'(id_admit));
      id_admit++;
    end
    if (on_cpu != '0) begin
      if (job_left_tab[int'(on_cpu)-1] != '0) job_left_tab[int'(on_cpu)-1]--;
      if (job_left_tab[int'(on_cpu)-1] != '0 && ready_ring.size() < QUEUE_DEPTH)
        ready_ring.push_back(on_cpu);
    end
    on_cpu = '0;
    if (ready_ring.size() > 0) on_cpu = ready_ring.pop_front();
    rep.slot_time  = clock_now;
    rep.running_id = on_cpu;
    rep.all_done   = (id_admit >= id_next) && (ready_ring.size() == 0) && (on_cpu == '0);
    if (clock_now != TIME_W'(TIME_MAX)) clock_now++;
    ticks_taken++;
    return 1'b1;
  endfunction

  task automatic queue_req(input logic kind, input int arr, input int serv);
    pending_req_t p;
    p.req.req_type     = kind;
    p.req.arrival_time = TIME_W'(arr);
    p.req.service_time = SERV_W'(serv);
    p.steady           = steady_run;
    pending.push_back(p);
    plan_items++;
    if (kind == REQ_TICK) begin
      if (plan_time < TIME_MAX) plan_time++;
    end else if (serv != 0 && plan_jobs < QUEUE_DEPTH) begin
      plan_jobs++;
    end
  endtask

  // driver: a request is taken at an edge with start high and busy low
  always @(posedge clk) begin
    bit           take;
    out_item_t    rep;
    pending_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = !start;
      if (start && !busy) begin
        accepted++;
        if (schedule_request(in_item, rep)) slots_due.push_back(rep);
        take = 1'b1;
      end
      if (take) begin
        if (pending.size() > 0 && (pending[0].steady || $urandom_range(0, 99) >= 14)) begin
          nxt = pending.pop_front();
          in_item <= nxt.req;
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: the result strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      reports_seen++;
      if (slots_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected slot report: expected none, actual time %0d id %0d done %0b",
                 $time, out_result.slot_time, out_result.running_id, out_result.all_done);
      end else begin
        want = slots_due.pop_front();
        if (out_result.slot_time !== want.slot_time) begin
          fail_count++;
          $display("%0t: slot_time mismatch: expected %0d actual %0d",
                   $time, want.slot_time, out_result.slot_time);
        end
        if (out_result.running_id !== want.running_id) begin
          fail_count++;
          $display("%0t: running_id mismatch at slot %0d: expected %0d actual %0d",
                   $time, want.slot_time, want.running_id, out_result.running_id);
        end
        if (out_result.all_done !== want.all_done) begin
          fail_count++;
          $display("%0t: all_done mismatch at slot %0d: expected %0b actual %0b",
                   $time, want.slot_time, want.all_done, out_result.all_done);
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n_sub;
    int arr;
    int serv;

    // ticks on an empty table, zero service, head-of-line blocking, full drain
    queue_req(REQ_TICK, 0, 0);
    queue_req(REQ_TICK, TIME_MAX, 16'hFFFF);
    queue_req(REQ_SUBMIT, 0, 0);
    queue_req(REQ_SUBMIT, TIME_MAX, 0);
    queue_req(REQ_SUBMIT, 0, 1);
    queue_req(REQ_SUBMIT, 3, 3);
    queue_req(REQ_SUBMIT, 0, 2);
    queue_req(REQ_SUBMIT, 9, 1);
    repeat (12) queue_req(REQ_TICK, 0, 0);

    // random batches: a few submits then a run of ticks; three ids kept back
    while (plan_items < 1800) begin
      steady_run = (plan_items >= 700 && plan_items < 1000);
      n_sub = $urandom_range(0, 3);
      for (int i = 0; i < n_sub; i++) begin
        if (plan_jobs >= QUEUE_DEPTH - 3 || $urandom_range(0, 9) == 0) begin
          queue_req(REQ_SUBMIT, $urandom_range(0, TIME_MAX), 0);
        end else begin
          if ($urandom_range(0, 3) == 0)
            arr = (plan_time > 12) ? plan_time - int'($urandom_range(0, 12)) : 0;
          else
            arr = plan_time + int'($urandom_range(0, 40));
          serv = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 16);
          queue_req(REQ_SUBMIT, arr, serv);
        end
      end
      repeat ($urandom_range(3, 50))
        queue_req(REQ_TICK, $urandom_range(0, TIME_MAX), $urandom_range(0, 65535));
    end

    // fill the table, then late and long jobs, a drop on a full table,
    // and a closing run of ticks
    steady_run = 1'b1;
    while (plan_jobs < QUEUE_DEPTH - 3) queue_req(REQ_SUBMIT, plan_time, $urandom_range(1, 16));
    queue_req(REQ_SUBMIT, 16'h8000, 16'hFFFF);
    queue_req(REQ_SUBMIT, 16'h7FFF, 1);
    queue_req(REQ_SUBMIT, TIME_MAX, 16'hFFFF);
    queue_req(REQ_SUBMIT, 0, 16'hFFFF);
    repeat (40) queue_req(REQ_TICK, 0, 0);
    repeat (4) queue_req(REQ_TICK, TIME_MAX, 16'hFFFF);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted < plan_items) @(posedge clk);
    while (slots_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d requests: %0d ticks, %0d jobs stored, %0d submits dropped",
             accepted, ticks_taken, jobs_stored, submits_dropped);
    $display("checked %0d slot reports up to time %0d in %0d cycles, %0d mismatches",
             reports_seen, clock_now, cycle_count, fail_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_job_mem.sv
hw/rtl/rrts_ready_fifo.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/round_robin_tick_scheduler_core.sv
test/tb.sv
